// File: hdl/cps_pkg.sv
// Shared types, codes and constants of the contactor pre-charge sequencer.
package cps_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int MS_W      = 16;
  localparam int RAW_W     = 12;
  localparam int MV_W      = 21;
  localparam int MA_W      = 21;
  localparam int PH_W      = 3;
  localparam int TIMER_W   = 32;
  localparam int NUM_W     = 20;
  localparam int DEN_W     = 16;
  localparam int PCT_W     = 7;
  localparam int LIMIT_W   = 20;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 20;
  localparam int IN_DATA_W = 72;
  localparam int OUT_W     = 16;

  // Divider operand width: raw * num fits in 32 bits
  localparam int DIV_W     = RAW_W + NUM_W;
  localparam int PCTPROD_W = DIV_W + PCT_W;
  localparam int LIM_W     = 29;

  localparam int PCT_DIV   = 100;
  localparam int MIN_MA    = 1000;

  // Register reset values
  localparam logic [NUM_W-1:0]   RST_BUS_NUM = 20'd1000000;
  localparam logic [DEN_W-1:0]   RST_BUS_DEN = 16'd4095;
  localparam logic [PCT_W-1:0]   RST_PCT     = 7'd95;
  localparam logic [LIMIT_W-1:0] RST_MATCH   = 20'd5000;
  localparam logic [MS_W-1:0]    RST_PRE_TO  = 16'd5000;
  localparam logic [MS_W-1:0]    RST_CLS_TO  = 16'd100;
  localparam logic [MS_W-1:0]    RST_WELD_MS = 16'd500;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_BUS_NUM  = 3'd0;
  localparam logic [IDX_W-1:0] REG_BUS_DEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PCT      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MATCH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_PRE_TO   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CLS_TO   = 3'd5;
  localparam logic [IDX_W-1:0] REG_WELD_MS  = 3'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_OPEN  = 2'd2
  } cmd_t;

  typedef enum logic [PH_W-1:0] {
    PH_OPEN      = 3'd0,
    PH_PRECHARGE = 3'd1,
    PH_CLOSING   = 3'd2,
    PH_CLOSED    = 3'd3,
    PH_OPENING   = 3'd4,
    PH_WELDED    = 3'd5
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic pct;
    logic commit;
  } cps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scale;
    logic div_done;
  } cps_stat_t;

endpackage

// File: hdl/cps_div.sv
// Restoring divider, one quotient bit per cycle, for bus voltage scaling.
module cps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cps_pkg::DIV_W-1:0]  dividend,
  input  logic [cps_pkg::DEN_W-1:0]  divisor,
  output logic                       done,
  output logic [cps_pkg::DIV_W-1:0]  quotient
);
  import cps_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] dsr_r, dsr_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done longer than one cycle");
`endif

endmodule

// File: hdl/cps_dp.sv
// Datapath: registers, item capture, bus scaling and phase update logic.
module cps_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cps_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]     cfg_data,
  input  cps_pkg::cps_cmd_t             cmd,
  output cps_pkg::cps_stat_t            stat,
  input  logic [cps_pkg::CMD_W-1:0]     in_tuser,
  input  logic [cps_pkg::IN_DATA_W-1:0] in_tdata,
  output logic [cps_pkg::OUT_W-1:0]     out_tdata
);
  import cps_pkg::*;

  // Configuration
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [PCT_W-1:0]   pct_r;
  logic [LIMIT_W-1:0] match_r;
  logic [MS_W-1:0]    pre_to_r, cls_to_r, weld_ms_r;

  // Captured item
  logic [CMD_W-1:0] cmd_r;
  logic [MS_W-1:0]  elapsed_r;
  logic [RAW_W-1:0] raw_r;
  logic [MV_W-1:0]  pack_mv_r;
  logic [MA_W-1:0]  pack_ma_r;
  logic             fb_pos_r, fb_neg_r;

  // Sequencer state
  phase_t           phase_r, phase_nxt;
  phase_t           reported_r, reported_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic             close_pend_r, close_pend_nxt;
  logic             open_pend_r, open_pend_nxt;
  logic             drv_pos_r, drv_pos_nxt;
  logic             drv_neg_r, drv_neg_nxt;
  logic             drv_pre_r, drv_pre_nxt;
  logic             weld_r, weld_nxt;

  // Scaling
  logic [DIV_W-1:0]     prod_r;
  logic [PCTPROD_W-1:0] pctprod_r;
  logic                 diff_ok_r;
  logic [DEN_W-1:0]     den_eff;
  logic                 div_done;
  logic [DIV_W-1:0]     bus_mv;
  logic [DIV_W-1:0]     pack_ext;
  logic [DIV_W-1:0]     vdiff;
  logic [LIM_W-1:0]     lim;
  logic                 close_ok;

  logic [TIMER_W:0]   tsum;
  logic [TIMER_W-1:0] t_new;
  logic [TIMER_W-1:0] t_pre;
  logic [MA_W-1:0]    ma_mag;
  logic [OUT_W-1:0]   out_nxt;
  logic [OUT_W-1:0]   out_r;

  assign den_eff = (den_r == '0) ? DEN_W'(1) : den_r;

  cps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_eff),
    .done     (div_done),
    .quotient (bus_mv)
  );

  assign stat.need_scale = (cmd_t'(cmd_r) == CMD_TICK) && (phase_r == PH_PRECHARGE)
                           && !open_pend_r;
  assign stat.div_done   = div_done;

  assign pack_ext = {(DIV_W-MV_W)'(0), pack_mv_r};
  assign vdiff    = (pack_ext > bus_mv) ? (pack_ext - bus_mv) : (bus_mv - pack_ext);

  // pack >= floor(x/100)  <=>  x < (pack + 1) * 100
  assign lim = LIM_W'(({(LIM_W-MV_W)'(0), pack_mv_r} + LIM_W'(1)) * LIM_W'(PCT_DIV));
  assign close_ok = (pctprod_r >= PCTPROD_W'(PCT_DIV))
                    && (pctprod_r < {(PCTPROD_W-LIM_W)'(0), lim})
                    && diff_ok_r;

  // Saturating phase timer
  assign tsum  = {1'b0, timer_r} + {(TIMER_W+1-MS_W)'(0), elapsed_r};
  assign t_new = tsum[TIMER_W] ? '1 : tsum[TIMER_W-1:0];
  // Timeout test in pre-charge sees the timer after a main close restarted it
  assign t_pre = close_ok ? '0 : t_new;

  assign ma_mag = pack_ma_r[MA_W-1] ? (MA_W'(0) - pack_ma_r) : pack_ma_r;

  always_comb begin
    phase_nxt      = phase_r;
    reported_nxt   = reported_r;
    timer_nxt      = timer_r;
    close_pend_nxt = close_pend_r;
    open_pend_nxt  = open_pend_r;
    drv_pos_nxt    = drv_pos_r;
    drv_neg_nxt    = drv_neg_r;
    drv_pre_nxt    = drv_pre_r;
    weld_nxt       = weld_r;
    case (cmd_t'(cmd_r))
      CMD_TICK: begin
        timer_nxt = t_new;
        case (phase_r)
          PH_OPEN: begin
            if (close_pend_r) begin
              close_pend_nxt = 1'b0;
              phase_nxt      = PH_PRECHARGE;
              timer_nxt      = '0;
              drv_neg_nxt    = 1'b1;
              drv_pre_nxt    = 1'b1;
            end
          end
          PH_PRECHARGE: begin
            if (open_pend_r) begin
              open_pend_nxt = 1'b0;
              phase_nxt     = PH_OPENING;
              timer_nxt     = '0;
              drv_pos_nxt   = 1'b0;
              drv_neg_nxt   = 1'b0;
              drv_pre_nxt   = 1'b0;
            end else begin
              if (close_ok) begin
                phase_nxt   = PH_CLOSING;
                timer_nxt   = '0;
                drv_pos_nxt = 1'b1;
                drv_pre_nxt = 1'b0;
              end
              if (t_pre >= {(TIMER_W-MS_W)'(0), pre_to_r}) begin
                phase_nxt   = PH_OPEN;
                timer_nxt   = '0;
                drv_pos_nxt = 1'b0;
                drv_neg_nxt = 1'b0;
                drv_pre_nxt = 1'b0;
              end
            end
          end
          PH_CLOSING: begin
            if (open_pend_r) begin
              open_pend_nxt = 1'b0;
              phase_nxt     = PH_OPENING;
              timer_nxt     = '0;
              drv_pos_nxt   = 1'b0;
              drv_neg_nxt   = 1'b0;
              drv_pre_nxt   = 1'b0;
            end else if (fb_pos_r && fb_neg_r) begin
              phase_nxt    = PH_CLOSED;
              timer_nxt    = '0;
              reported_nxt = PH_CLOSED;
            end else if (t_new >= {(TIMER_W-MS_W)'(0), cls_to_r}) begin
              phase_nxt   = PH_OPEN;
              timer_nxt   = '0;
              drv_pos_nxt = 1'b0;
              drv_neg_nxt = 1'b0;
              drv_pre_nxt = 1'b0;
            end
          end
          PH_CLOSED: begin
            if (open_pend_r) begin
              open_pend_nxt = 1'b0;
              phase_nxt     = PH_OPENING;
              timer_nxt     = '0;
              drv_pos_nxt   = 1'b0;
              drv_neg_nxt   = 1'b0;
              drv_pre_nxt   = 1'b0;
            end
          end
          PH_OPENING: begin
            if (ma_mag < MA_W'(MIN_MA)) begin
              phase_nxt    = PH_OPEN;
              timer_nxt    = '0;
              reported_nxt = PH_OPEN;
            end else if (t_new >= {(TIMER_W-MS_W)'(0), weld_ms_r}) begin
              phase_nxt    = PH_WELDED;
              reported_nxt = PH_WELDED;
              weld_nxt     = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_CLOSE: begin
        if (phase_r == PH_OPEN) close_pend_nxt = 1'b1;
      end
      CMD_OPEN: begin
        if (phase_r inside {PH_PRECHARGE, PH_CLOSING, PH_CLOSED}) open_pend_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // phase, pos, neg, pre, reported, weld, faulted from bit 0 up
  assign out_nxt = {5'b0, (phase_nxt == PH_WELDED), weld_nxt, reported_nxt,
                    drv_pre_nxt, drv_neg_nxt, drv_pos_nxt, phase_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r        <= RST_BUS_NUM;
      den_r        <= RST_BUS_DEN;
      pct_r        <= RST_PCT;
      match_r      <= RST_MATCH;
      pre_to_r     <= RST_PRE_TO;
      cls_to_r     <= RST_CLS_TO;
      weld_ms_r    <= RST_WELD_MS;
      phase_r      <= PH_OPEN;
      reported_r   <= PH_OPEN;
      timer_r      <= '0;
      close_pend_r <= 1'b0;
      open_pend_r  <= 1'b0;
      drv_pos_r    <= 1'b0;
      drv_neg_r    <= 1'b0;
      drv_pre_r    <= 1'b0;
      weld_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUS_NUM: num_r     <= cfg_data[NUM_W-1:0];
          REG_BUS_DEN: den_r     <= cfg_data[DEN_W-1:0];
          REG_PCT:     pct_r     <= cfg_data[PCT_W-1:0];
          REG_MATCH:   match_r   <= cfg_data[LIMIT_W-1:0];
          REG_PRE_TO:  pre_to_r  <= cfg_data[MS_W-1:0];
          REG_CLS_TO:  cls_to_r  <= cfg_data[MS_W-1:0];
          REG_WELD_MS: weld_ms_r <= cfg_data[MS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        phase_r      <= phase_nxt;
        reported_r   <= reported_nxt;
        timer_r      <= timer_nxt;
        close_pend_r <= close_pend_nxt;
        open_pend_r  <= open_pend_nxt;
        drv_pos_r    <= drv_pos_nxt;
        drv_neg_r    <= drv_neg_nxt;
        drv_pre_r    <= drv_pre_nxt;
        weld_r       <= weld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_tuser;
      elapsed_r <= in_tdata[15:0];
      raw_r     <= in_tdata[27:16];
      pack_mv_r <= in_tdata[48:28];
      pack_ma_r <= in_tdata[69:49];
      fb_pos_r  <= in_tdata[70];
      fb_neg_r  <= in_tdata[71];
    end
    if (cmd.mul) prod_r <= DIV_W'({{(DIV_W-RAW_W){1'b0}}, raw_r} * {{(DIV_W-NUM_W){1'b0}}, num_r});
    if (cmd.pct) begin
      pctprod_r <= PCTPROD_W'({{(PCTPROD_W-DIV_W){1'b0}}, bus_mv}
                              * {{(PCTPROD_W-PCT_W){1'b0}}, pct_r});
      diff_ok_r <= (vdiff < {(DIV_W-LIMIT_W)'(0), match_r});
    end
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_tdata = out_r;

`ifndef SYNTHESIS
  a_weld_phase: assert property (@(posedge clk) disable iff (!rst_n)
    weld_r |-> (phase_r == PH_WELDED))
    else $error("weld fault latched outside welded phase");
  a_pre_coil: assert property (@(posedge clk) disable iff (!rst_n)
    drv_pre_r |-> (phase_r == PH_PRECHARGE))
    else $error("pre-charge coil driven outside pre-charge");
  a_open_main: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OPEN) |-> !drv_pos_r)
    else $error("main contactor driven while open");
`endif

endmodule

// File: hdl/cps_ctrl.sv
// Controller: item handshake and sequencing of the scaling steps.
module cps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output cps_pkg::cps_cmd_t  cmd,
  input  cps_pkg::cps_stat_t stat
);
  import cps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIVWAIT,
    S_PCT,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.need_scale ? S_DIVGO : S_COMMIT;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (stat.div_done) state_nxt = S_PCT;
      end
      S_PCT: begin
        cmd.pct   = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL))
    else $error("accepted item not processed");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> out_free)
    else $error("result overwrites one not yet taken");
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(cmd.commit))
    else $error("result valid without a commit");
`endif

endmodule

// File: hdl/contactor_precharge_sequencer_unit.sv
// Top level of the contactor pre-charge sequencer.
//
//  channel | ports                        | content
//  --------+------------------------------+------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | tuser command, tdata tick measurements
//  out     | out_tvalid/tready/tdata      | phase, coil drives, reported phase, faults
//  cfg     | cfg_valid/ready/index/data   | register writes, always ready
//
// A request, a tick outside pre-charge or a tick that takes a pending open passes
// the multiply step and then commits. A scaling pre-charge tick commits after the
// 32-step restoring divider plus its multiply and percent steps.
// in_tready returns together with out_tvalid, so no item is taken before the last commits.
// rst_n is synchronous; it restores register defaults and the open phase.
// A new item is taken while the last result waits; its result holds until out is free.
module contactor_precharge_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // elapsed_ms, bus_adc_raw, pack_mv, pack_ma, feedback_pos, feedback_neg
  input  logic [cps_pkg::IN_DATA_W-1:0] in_tdata,
  // command
  input  logic [cps_pkg::CMD_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // phase, drive_pos, drive_neg, drive_precharge, reported_phase, weld_fault,
  // faulted, zero fill
  output logic [cps_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cps_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]     cfg_data
);
  import cps_pkg::*;

  cps_cmd_t  cmd;
  cps_stat_t stat;

  assign cfg_ready = 1'b1;

  cps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  cps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
